// ===== hw/rtl/htfr_pkg.sv =====
// shared types and constants for the header/tail frame receiver
`timescale 1ns / 1ps
`default_nettype none

package htfr_pkg;

   localparam int MAX_FRAME_DEFAULT = 256;
   localparam int MIN_FRAME_LEN     = 4;
   localparam int BYTE_W            = 8;
   localparam int CSR_INDEX_W       = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER = 1'b0,
      CSR_TAIL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_value;
      logic [BYTE_W-1:0] tail_value;
   } csr_regs_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] position;
      logic              frame_end;
      logic              checksum_ok;
      logic              overflow_abort;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/htfr_csr.sv =====
// configuration registers: header and tail byte values
`timescale 1ns / 1ps
`default_nettype none

module htfr_csr
   import htfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata,
   output csr_regs_type                regs
);

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER: regs_in.header_value = csr_wdata;
            CSR_TAIL:   regs_in.tail_value   = csr_wdata;
            default:    regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.header_value <= 8'd170;
         regs_ff.tail_value   <= 8'd85;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/htfr_frame_track.sv =====
// frame state: byte count, running xor and last byte, plus the per-beat result
`timescale 1ns / 1ps
`default_nettype none

module htfr_frame_track
   import htfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  csr_regs_type           regs,
   output logic                   has_result,
   output result_type             result
);

   localparam int CNT_W = $clog2(MAX_FRAME);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [BYTE_W-1:0] xor_ff;
   logic [BYTE_W-1:0] xor_in;
   logic [BYTE_W-1:0] prev_ff;
   logic [BYTE_W-1:0] prev_in;

   logic [CNT_W:0]          count_next;
   logic [CNT_W+BYTE_W-1:0] pos_wide;
   logic                    idle;
   logic                    closes;
   logic                    fills;

   always_comb begin
      idle       = (count_ff == '0);
      count_next = {1'b0, count_ff} + (CNT_W+1)'(1);
      pos_wide   = {{BYTE_W{1'b0}}, count_ff};
      closes     = (rx_byte == regs.tail_value) &&
                   (count_next >= (CNT_W+1)'(MIN_FRAME_LEN));
      fills      = (count_next >= (CNT_W+1)'(MAX_FRAME));

      has_result            = !idle || (rx_byte == regs.header_value);
      result.data_byte      = rx_byte;
      result.position       = pos_wide[BYTE_W-1:0];
      result.frame_end      = closes;
      result.checksum_ok    = closes && (xor_ff == prev_ff);
      result.overflow_abort = !closes && fills;

      count_in = count_ff;
      xor_in   = xor_ff;
      prev_in  = prev_ff;
      if (step && has_result) begin
         if (closes || fills) begin
            count_in = '0;
            xor_in   = '0;
            prev_in  = '0;
         end else begin
            count_in = count_next[CNT_W-1:0];
            xor_in   = xor_ff ^ prev_ff;
            prev_in  = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         xor_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/header_tail_frame_receiver_core.sv =====
// top level of the header/tail frame receiver with xor checksum check
//
//   channel | dir | beat                                   | handshake
//   req_    | in  | one received byte (rx_byte)             | req_valid / req_ready
//   rsp_    | out | frame byte, position and end/ok/abort   | rsp_valid / rsp_ready
//   csr_    | in  | header/tail byte write                  | csr_write_en, no wait
//
// one byte per cycle sustained while rsp is not stalled: input register, then compare/count/xor, then result register
// an accepted req byte goes to the input register, then its result to the result register that drives rsp_valid
// bytes outside a frame that are not the header pass through the input register but give no rsp beat
// synchronous reset clears both pipeline valids and the frame state, reloads csr defaults
// a stalled rsp holds the input register; req_ready drops only while both are full
`timescale 1ns / 1ps
`default_nettype none

module header_tail_frame_receiver_core
   import htfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input byte channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [BYTE_W-1:0]           rsp_data_byte,
   output logic [BYTE_W-1:0]           rsp_position,
   output logic                        rsp_frame_end,
   output logic                        rsp_checksum_ok,
   output logic                        rsp_overflow_abort,
   // configuration writes
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata
);

   csr_regs_type regs;

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [BYTE_W-1:0] in_byte_in;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;

   logic       advance;
   logic       has_result;
   result_type result;

   htfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .regs         (regs)
   );

   htfr_frame_track #(
      .MAX_FRAME (MAX_FRAME)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .regs       (regs),
      .has_result (has_result),
      .result     (result)
   );

   // the held byte moves on when the result slot is free or being emptied
   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = has_result;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_position       = rsp_ff.position;
   assign rsp_frame_end      = rsp_ff.frame_end;
   assign rsp_checksum_ok    = rsp_ff.checksum_ok;
   assign rsp_overflow_abort = rsp_ff.overflow_abort;

`ifndef SYNTHESIS
   localparam logic [BYTE_W-1:0] LastPos = BYTE_W'(MAX_FRAME - 1);

   // a closing tail and an overflow abort never share a beat
   a_end_xor_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_end && rsp_overflow_abort))
      else $error("frame end and overflow abort on the same beat");

   // checksum status only reported on a closing tail
   a_ok_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_frame_end)
      else $error("checksum ok without frame end");

   // abort comes only on the byte that fills the frame
   a_abort_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_abort |-> rsp_position == LastPos)
      else $error("overflow abort at wrong position");

   // a stalled result must not be overwritten by the pipeline
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ff))
      else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
